@@ rtl/ccks_pkg.sv @@
// Shared types, constants and round functions for the ChaCha20 keystream generator.
`default_nettype none

package ccks_pkg;

  // Block constants ("expand 32-byte k")
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam int DoubleRounds = 10;
  localparam int NumRounds    = 2 * DoubleRounds;
  localparam int RndW         = $clog2(NumRounds);
  localparam logic [RndW-1:0] LastRound = RndW'(NumRounds - 1);

  // Configuration register file
  localparam int NumRegs = 6;
  localparam int PaddrW  = $clog2(8 * NumRegs);
  localparam int DataW   = 64;

  typedef enum logic [2:0] {
    REG_KEY0       = 3'd0,
    REG_KEY1       = 3'd1,
    REG_KEY2       = 3'd2,
    REG_KEY3       = 3'd3,
    REG_NONCE_LOW  = 3'd4,
    REG_NONCE_HIGH = 3'd5
  } reg_idx_e;

  // Largest block slice in bytes
  localparam logic [6:0] MaxBytes = 7'd64;

  typedef struct packed {
    logic [6:0] want_bytes;
    logic       restart;
  } req_t;

  typedef struct packed {
    logic [63:0] random_word;
    logic [3:0]  valid_bytes;
    logic        last;
  } res_t;

  // One block job handed from the front end to the core
  typedef struct packed {
    logic [31:0] counter;
    logic [6:0]  want;
  } job_t;

  typedef struct packed {
    logic [3:0][63:0] key_word;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } cfg_t;

  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINISH
  } core_state_e;

  // Build the sixteen input words of a block
  function automatic state_t init_state(cfg_t cfg, logic [31:0] ctr);
    state_t s;
    s[0] = Sigma0;
    s[1] = Sigma1;
    s[2] = Sigma2;
    s[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2*i] = cfg.key_word[i][31:0];
      s[5 + 2*i] = cfg.key_word[i][63:32];
    end
    s[12] = ctr;
    s[13] = cfg.nonce_low[31:0];
    s[14] = cfg.nonce_low[63:32];
    s[15] = cfg.nonce_high;
    return s;
  endfunction

  // One quarter round; word 0 is a, 1 is b, 2 is c, 3 is d
  function automatic quad_t quarter(quad_t q);
    logic [31:0] a, b, c, d;
    quad_t r;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    r[0] = a; r[1] = b; r[2] = c; r[3] = d;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ccks_front.sv @@
// Front end: accepts requests, keeps the block counter and queues block jobs.
`default_nettype none

module ccks_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ccks_pkg::req_t in_data_i,
  input  wire logic          space_i,
  output logic               push_o,
  output ccks_pkg::job_t     job_o
);
  import ccks_pkg::*;

  logic [31:0] ctr_q, ctr_d;
  logic [31:0] ctr_base;
  logic        accept;
  logic        zero_req;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign zero_req   = (in_data_i.want_bytes == 7'd0);

  // Classify the request: restart, empty request, oversized request
  always_comb begin
    ctr_base    = in_data_i.restart ? 32'd0 : ctr_q;
    ctr_d       = ctr_q;
    push_o      = 1'b0;
    job_o.counter = ctr_base;
    job_o.want  = in_data_i.want_bytes[6] ? MaxBytes : in_data_i.want_bytes;
    if (accept) begin
      ctr_d  = zero_req ? ctr_base : ctr_base + 32'd1;
      push_o = !zero_req;
    end
  end

  // Hold the block counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ccks_queue.sv @@
// Two-entry job queue between the front end and the core.
`default_nettype none

module ccks_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ccks_pkg::job_t job_i,
  output logic                space_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output ccks_pkg::job_t      job_o
);
  import ccks_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ccks_core.sv @@
// Back end: round unit with four quarter-round lanes, final add and word emitter.
`default_nettype none

module ccks_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ccks_pkg::cfg_t cfg_i,
  input  wire logic           job_valid_i,
  input  wire ccks_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ccks_pkg::res_t      out_data_o
);
  import ccks_pkg::*;

  core_state_e      state_q, state_d;
  state_t           st_q, st_d;
  state_t           st_round;
  state_t           init_job;
  state_t           init_cur;
  logic [31:0]      ctr_q, ctr_d;
  logic [6:0]       want_q, want_d;
  logic [RndW-1:0]  rnd_q, rnd_d;

  logic [7:0][63:0] buf_q, buf_d;
  logic             emit_q, emit_d;
  logic [6:0]       left_q, left_d;
  logic [2:0]       widx_q, widx_d;
  logic             load_buf;

  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             out_free;
  logic [63:0]      word;
  logic [3:0]       vb;
  logic             last;

  assign init_job = init_state(cfg_i, job_i.counter);
  assign init_cur = init_state(cfg_i, ctr_q);

  // One round: columns on even steps, diagonals on odd steps
  always_comb begin
    quad_t q;
    quad_t r;
    st_round = st_q;
    for (int i = 0; i < 4; i++) begin
      if (!rnd_q[0]) begin
        q = {st_q[12 + i], st_q[8 + i], st_q[4 + i], st_q[i]};
        r = quarter(q);
        st_round[i]      = r[0];
        st_round[4 + i]  = r[1];
        st_round[8 + i]  = r[2];
        st_round[12 + i] = r[3];
      end else begin
        q = {st_q[12 + ((i + 3) & 3)], st_q[8 + ((i + 2) & 3)],
             st_q[4 + ((i + 1) & 3)], st_q[i]};
        r = quarter(q);
        st_round[i]                  = r[0];
        st_round[4 + ((i + 1) & 3)]  = r[1];
        st_round[8 + ((i + 2) & 3)]  = r[2];
        st_round[12 + ((i + 3) & 3)] = r[3];
      end
    end
  end

  // Sequence load, rounds and final add
  always_comb begin
    state_d  = state_q;
    st_d     = st_q;
    ctr_d    = ctr_q;
    want_d   = want_q;
    rnd_d    = rnd_q;
    pop_o    = 1'b0;
    load_buf = 1'b0;
    unique case (state_q)
      CORE_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          st_d    = init_job;
          ctr_d   = job_i.counter;
          want_d  = job_i.want;
          rnd_d   = '0;
          state_d = CORE_ROUND;
        end
      end
      CORE_ROUND: begin
        st_d  = st_round;
        rnd_d = rnd_q + RndW'(1);
        if (rnd_q == LastRound) begin
          state_d = CORE_FINISH;
        end
      end
      CORE_FINISH: begin
        if (!emit_q) begin
          load_buf = 1'b1;
          state_d  = CORE_IDLE;
        end
      end
      default: begin
        state_d = CORE_IDLE;
      end
    endcase
  end

  // Pick the current word and trim it to the bytes left
  always_comb begin
    vb   = (left_q > 7'd8) ? 4'd8 : left_q[3:0];
    last = (left_q <= 7'd8);
    word = buf_q[widx_q];
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= vb) begin
        word[8*b +: 8] = 8'h00;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Fill the emit buffer and drain it one word at a time
  always_comb begin
    buf_d       = buf_q;
    emit_d      = emit_q;
    left_d      = left_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_q && out_free) begin
      out_valid_d       = 1'b1;
      out_d.random_word = word;
      out_d.valid_bytes = vb;
      out_d.last        = last;
      widx_d            = widx_q + 3'd1;
      left_d            = left_q - 7'd8;
      if (last) begin
        emit_d = 1'b0;
      end
    end
    if (load_buf) begin
      for (int i = 0; i < 8; i++) begin
        buf_d[i] = {st_q[2*i + 1] + init_cur[2*i + 1], st_q[2*i] + init_cur[2*i]};
      end
      emit_d = 1'b1;
      left_d = want_q;
      widx_d = 3'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CORE_IDLE;
      rnd_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    ctr_q  <= ctr_d;
    want_q <= want_d;
    buf_q  <= buf_d;
    left_q <= left_d;
    widx_q <= widx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/chacha20_keystream_generator.sv @@
// A request's words come out one per cycle while out_ready_i does not stall the output.
// Each 64-byte block is loaded, then passed through the round unit, which applies one
// full round (four quarter rounds) per cycle for 20 rounds, and then gets its final add.
// Requests for zero bytes produce nothing. A two-entry job queue
// lets requests be taken while a block is computed and earlier words drain.
// Reset: block counter zero, key and nonce at their default seed, the job queue empty.
`default_nettype none

module chacha20_keystream_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ccks_pkg::req_t                in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ccks_pkg::res_t                     out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ccks_pkg::PaddrW-1:0]   paddr,
  input  wire logic [ccks_pkg::DataW-1:0]    pwdata,
  output logic [ccks_pkg::DataW-1:0]         prdata,
  output logic                               pready
);
  import ccks_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     q_space;
  logic     q_push;
  job_t     q_job_in;
  logic     q_valid;
  logic     q_pop;
  job_t     q_job_out;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[PaddrW-1:3]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_word[0] <= 64'h0706050403020100;
      cfg_q.key_word[1] <= 64'h0F0E0D0C0B0A0908;
      cfg_q.key_word[2] <= 64'h1716151413121110;
      cfg_q.key_word[3] <= 64'h1F1E1D1C1B1A1918;
      cfg_q.nonce_low   <= 64'h44332211DDCCBBAA;
      cfg_q.nonce_high  <= 32'h88776655;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY0:       cfg_q.key_word[0] <= pwdata;
        REG_KEY1:       cfg_q.key_word[1] <= pwdata;
        REG_KEY2:       cfg_q.key_word[2] <= pwdata;
        REG_KEY3:       cfg_q.key_word[3] <= pwdata;
        REG_NONCE_LOW:  cfg_q.nonce_low   <= pwdata;
        REG_NONCE_HIGH: cfg_q.nonce_high  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_KEY0:       prdata = cfg_q.key_word[0];
      REG_KEY1:       prdata = cfg_q.key_word[1];
      REG_KEY2:       prdata = cfg_q.key_word[2];
      REG_KEY3:       prdata = cfg_q.key_word[3];
      REG_NONCE_LOW:  prdata = cfg_q.nonce_low;
      REG_NONCE_HIGH: prdata = {32'd0, cfg_q.nonce_high};
      default:        prdata = '0;
    endcase
  end

  ccks_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .space_i    (q_space),
    .push_o     (q_push),
    .job_o      (q_job_in)
  );

  ccks_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .space_o (q_space),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (q_job_out)
  );

  ccks_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
